/* rtl/core/bsgff_pkg.sv */
// Types and constants shared by the bitmap set/get/find-first block.
package bsgff_pkg;

	localparam int CountW = 11;
	localparam int PosW   = 10;
	localparam int OpW    = 3;

	localparam logic [CountW-1:0] CountReset = 11'd1024;

	localparam logic [OpW-1:0] OpWrite    = 3'd0;
	localparam logic [OpW-1:0] OpRead     = 3'd1;
	localparam logic [OpW-1:0] OpFindZero = 3'd2;
	localparam logic [OpW-1:0] OpFindOne  = 3'd3;
	localparam logic [OpW-1:0] OpClear    = 3'd4;

	typedef struct packed {
		logic [OpW-1:0]  opcode;
		logic [PosW-1:0] position;
		logic            bit_value;
	} req_t;

	typedef struct packed {
		logic [CountW-1:0] found_index;
		logic              read_bit;
		logic              index_fault;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_RESP
	} state_t;

endpackage

/* rtl/core/bsgff_word_eval.sv */
// Masks one flag word to a window and encodes the first matching bit.
module bsgff_word_eval #(
	parameter int WORD_BITS = 64,
	parameter int XW        = 12
) (
	input  logic [WORD_BITS-1:0]         data,
	input  logic [XW-1:0]                base,
	input  logic [XW-1:0]                start,
	input  logic [XW-1:0]                limit,
	input  logic                         want_one,
	output logic                         hit,
	output logic [$clog2(WORD_BITS)-1:0] first
);

	localparam int OW = $clog2(WORD_BITS);

	logic [XW-1:0]        lo;
	logic [XW-1:0]        hi;
	logic [WORD_BITS-1:0] cand;

	assign lo = (start > base) ? start - base : '0;
	assign hi = (limit > base) ? limit - base : '0;

	always_comb begin
		for (int b = 0; b < WORD_BITS; b++) begin
			cand[b] = (data[b] == want_one) && (XW'(b) >= lo) && (XW'(b) < hi);
		end
	end

	always_comb begin
		first = '0;
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (cand[b]) begin
				first = OW'(b);
			end
		end
	end

	assign hit = |cand;

endmodule

/* rtl/core/bitmap_set_get_find_first.sv */
// Bitmap flag store with bit write/read, clear-all and find-first-zero/one.
//
//  port group | dir | handshake             | word
//  req        | in  | req_valid / req_ready | bsgff_pkg::req_t
//  rsp        | out | rsp_valid / rsp_ready | bsgff_pkg::rsp_t
//  cfg        | in  | cfg_we                | cfg_wdata (bit_count)
//
// Write, read and find scan the flag RAM one word per cycle from word 0; find-zero
// and find-one share one word evaluator.
// Out-of-range requests skip the scan; clear-all sweeps the RAM to zero, then answers.
// After reset the RAM is swept to zero before req_ready rises.
// One request at a time; a finished response waits in the rsp register.
module bitmap_set_get_find_first #(
	parameter int MAX_BITS  = 1024,
	parameter int WORD_BITS = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  bsgff_pkg::req_t              req,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output bsgff_pkg::rsp_t              rsp,
	input  logic                         cfg_we,
	input  logic [bsgff_pkg::CountW-1:0] cfg_wdata
);

	localparam int WORD_COUNT = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW  = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam int OW  = $clog2(WORD_BITS);
	localparam int BW  = $clog2(WORD_COUNT * WORD_BITS + WORD_BITS + 1);
	localparam int XW  = (BW > bsgff_pkg::CountW + 1) ? BW : bsgff_pkg::CountW + 1;
	localparam logic [AW-1:0] LastAddr = AW'(WORD_COUNT - 1);
	localparam logic [XW-1:0] MaxX     = XW'(MAX_BITS);
	localparam logic [XW-1:0] WordX    = XW'(WORD_BITS);

	logic [WORD_BITS-1:0] mem [WORD_COUNT];

	bsgff_pkg::state_t state_q, st_d;

	logic [bsgff_pkg::CountW-1:0]    bit_count_q;
	logic [bsgff_pkg::CountW-1:0]    count_q;
	logic [bsgff_pkg::OpW-1:0]       op_q;
	logic [bsgff_pkg::PosW-1:0]      pos_q;
	logic                            val_q;
	logic                            pend_q;
	logic [AW-1:0]                   addr_q;
	logic                            issue_done_q;
	logic [XW-1:0]                   base_q;
	logic                            vld_s1;
	logic [XW-1:0]                   base_s1;
	logic [AW-1:0]                   addr_s1;
	logic [WORD_BITS-1:0]            data_s1;
	bsgff_pkg::rsp_t                 res_q, res_d;
	bsgff_pkg::rsp_t                 rsp_q;
	logic                            rsp_valid_q;

	logic [XW-1:0]          live_x;
	logic [XW-1:0]          cnt_x;
	logic [XW-1:0]          pos_x;
	logic                   accept;
	logic                   start_scan;
	logic                   start_clear;
	logic                   res_load;
	logic                   mem_we;
	logic [AW-1:0]          mem_waddr;
	logic [WORD_BITS-1:0]   mem_wdata;
	logic [WORD_BITS-1:0]   mod_word;
	logic                   in_word;
	logic [OW-1:0]          off;
	logic                   hit;
	logic [OW-1:0]          first;
	logic                   rsp_free;

	assign live_x   = (XW'(bit_count_q) > MaxX) ? MaxX : XW'(bit_count_q);
	assign cnt_x    = XW'(count_q);
	assign pos_x    = XW'(pos_q);
	assign accept   = req_valid && req_ready;
	assign rsp_free = !rsp_valid_q || rsp_ready;

	assign in_word = (pos_x >= base_s1) && (pos_x < base_s1 + WordX);
	assign off     = OW'(pos_x - base_s1);

	always_comb begin
		mod_word      = data_s1;
		mod_word[off] = val_q;
	end

	bsgff_word_eval #(
		.WORD_BITS(WORD_BITS),
		.XW       (XW)
	) u_eval (
		.data    (data_s1),
		.base    (base_s1),
		.start   (pos_x),
		.limit   (cnt_x),
		.want_one(op_q == bsgff_pkg::OpFindOne),
		.hit     (hit),
		.first   (first)
	);

	always_comb begin
		st_d        = state_q;
		res_d       = '0;
		res_load    = 1'b0;
		start_scan  = 1'b0;
		start_clear = 1'b0;
		mem_we      = 1'b0;
		mem_waddr   = addr_q;
		mem_wdata   = '0;
		req_ready   = (state_q == bsgff_pkg::ST_IDLE);
		unique case (state_q)
			bsgff_pkg::ST_CLEAR: begin
				mem_we = 1'b1;
				if (addr_q == LastAddr) begin
					st_d = pend_q ? bsgff_pkg::ST_RESP : bsgff_pkg::ST_IDLE;
				end
			end
			bsgff_pkg::ST_IDLE: begin
				if (accept) begin
					res_load = 1'b1;
					st_d     = bsgff_pkg::ST_RESP;
					case (req.opcode) inside
						bsgff_pkg::OpWrite, bsgff_pkg::OpRead: begin
							if (XW'(req.position) >= live_x) begin
								res_d.index_fault = 1'b1;
							end else begin
								start_scan = 1'b1;
								st_d       = bsgff_pkg::ST_SCAN;
							end
						end
						bsgff_pkg::OpFindZero, bsgff_pkg::OpFindOne: begin
							if (XW'(req.position) >= live_x) begin
								res_d.found_index = bsgff_pkg::CountW'(live_x);
							end else begin
								start_scan = 1'b1;
								st_d       = bsgff_pkg::ST_SCAN;
							end
						end
						bsgff_pkg::OpClear: begin
							start_clear = 1'b1;
							st_d        = bsgff_pkg::ST_CLEAR;
						end
						default: begin
						end
					endcase
				end
			end
			bsgff_pkg::ST_SCAN: begin
				if (vld_s1) begin
					case (op_q)
						bsgff_pkg::OpWrite: begin
							if (in_word) begin
								mem_we    = 1'b1;
								mem_waddr = addr_s1;
								mem_wdata = mod_word;
								res_load  = 1'b1;
								st_d      = bsgff_pkg::ST_RESP;
							end
						end
						bsgff_pkg::OpRead: begin
							if (in_word) begin
								res_d.read_bit = data_s1[off];
								res_load       = 1'b1;
								st_d           = bsgff_pkg::ST_RESP;
							end
						end
						default: begin
							if (hit) begin
								res_d.found_index = bsgff_pkg::CountW'(base_s1 + XW'(first));
								res_load          = 1'b1;
								st_d              = bsgff_pkg::ST_RESP;
							end else if (base_s1 + WordX >= cnt_x) begin
								res_d.found_index = count_q;
								res_load          = 1'b1;
								st_d              = bsgff_pkg::ST_RESP;
							end
						end
					endcase
				end
			end
			bsgff_pkg::ST_RESP: begin
				if (rsp_free) begin
					st_d = bsgff_pkg::ST_IDLE;
				end
			end
			default: begin
				st_d = bsgff_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= bsgff_pkg::ST_CLEAR;
			bit_count_q  <= bsgff_pkg::CountReset;
			pend_q       <= 1'b0;
			addr_q       <= '0;
			issue_done_q <= 1'b0;
			vld_s1       <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q <= st_d;
			if (cfg_we) begin
				bit_count_q <= cfg_wdata;
			end
			if (start_clear || start_scan) begin
				addr_q       <= '0;
				issue_done_q <= 1'b0;
				vld_s1       <= 1'b0;
				pend_q       <= start_clear;
			end else if (state_q == bsgff_pkg::ST_CLEAR) begin
				addr_q <= addr_q + AW'(1);
			end else if (state_q == bsgff_pkg::ST_SCAN) begin
				vld_s1 <= !issue_done_q;
				if (!issue_done_q) begin
					if (addr_q == LastAddr) begin
						issue_done_q <= 1'b1;
					end else begin
						addr_q <= addr_q + AW'(1);
					end
				end
			end
			if (state_q == bsgff_pkg::ST_RESP && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= req.opcode;
			pos_q   <= req.position;
			val_q   <= req.bit_value;
			count_q <= bsgff_pkg::CountW'(live_x);
		end
		if (start_scan) begin
			base_q <= '0;
		end else if (state_q == bsgff_pkg::ST_SCAN && !issue_done_q) begin
			base_q <= base_q + WordX;
		end
		base_s1 <= base_q;
		addr_s1 <= addr_q;
		if (res_load) begin
			res_q <= res_d;
		end
		if (state_q == bsgff_pkg::ST_RESP && rsp_free) begin
			rsp_q <= res_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		data_s1 <= mem[addr_q];
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
